// ----- rtl/core/chmc_pkg.sv -----
// Shared types, constants and helpers for the charlieplexed matrix controller.
// Used by the front, queue, back and top-level modules; no dependencies.
package chmc_pkg;

  localparam int SIZE       = 10;
  localparam int LINES      = SIZE + 1;
  localparam int HALF_ROWS  = 20;
  localparam int HALF_WIDTH = 5;
  localparam int PINS       = 16;
  localparam int QDEPTH     = 2;

  localparam logic [7:0] CMD_REWIND = 8'h80;
  localparam logic [7:0] CMD_SWAP   = 8'h40;

  localparam logic IN_BYTE   = 1'b0;
  localparam logic IN_TICK   = 1'b1;
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  // Pin of each scan line: driven low while that line is scanned, high for line SIZE.
  localparam logic [3:0] PIN_OF_LINE [LINES] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
  };

  typedef enum logic [1:0] {
    OP_REWIND,
    OP_SWAP,
    OP_WRITE,
    OP_SCAN
  } op_t;

  // One classified transaction as it travels from the front to the back.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [4:0] pos;
    logic [3:0] line;
  } cmd_t;

  // Spread the bits of a frame word onto the pins of their lines.
  function automatic logic [PINS-1:0] remap_pins(input logic [SIZE-1:0] word);
    logic [PINS-1:0] res;
    res = '0;
    for (int i = 0; i < SIZE; i++) begin
      res[PIN_OF_LINE[i]] = word[i];
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/chmc_front.sv -----
// Front part: accepts input transactions, classifies them and tracks the
// write position and scan line. Depends on chmc_pkg.
module chmc_front import chmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] rx_byte,
  input  logic       q_space,
  output logic       push,
  output cmd_t       cmd
);

  logic [4:0] write_pos, write_pos_next, pos_eff;
  logic [3:0] scan_line, scan_line_next, line_eff;

  assign in_ready = q_space;
  assign push     = in_valid && q_space;

  always_comb begin
    pos_eff  = (write_pos < 5'(HALF_ROWS)) ? write_pos : '0;
    line_eff = (scan_line <= 4'(SIZE)) ? scan_line : '0;

    cmd.data = rx_byte;
    cmd.pos  = pos_eff;
    cmd.line = line_eff;
    write_pos_next = write_pos;
    scan_line_next = scan_line;

    if (op == IN_TICK) begin
      cmd.op = OP_SCAN;
      scan_line_next = (line_eff == 4'(SIZE)) ? '0 : line_eff + 4'd1;
    end else if (rx_byte == CMD_REWIND) begin
      cmd.op = OP_REWIND;
      write_pos_next = '0;
    end else if (rx_byte == CMD_SWAP) begin
      cmd.op = OP_SWAP;
    end else begin
      cmd.op = OP_WRITE;
      write_pos_next = (pos_eff == 5'(HALF_ROWS - 1)) ? '0 : pos_eff + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      scan_line <= '0;
    end else if (push) begin
      write_pos <= write_pos_next;
      scan_line <= scan_line_next;
    end
  end

endmodule

// ----- rtl/core/chmc_queue.sv -----
// Two-entry queue of classified transactions between front and back.
// Depends on chmc_pkg for the entry type and depth.
module chmc_queue import chmc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic not_empty,
  output logic not_full,
  output cmd_t head
);

  cmd_t       entries [QDEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign not_empty = (count != 2'd0);
  assign not_full  = (count != 2'(QDEPTH));
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/chmc_back.sv -----
// Back part: holds both frames, carries out queued transactions and keeps
// the output register. Depends on chmc_pkg.
module chmc_back import chmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             kind,
  output logic [7:0]       echo_byte,
  output logic [PINS-1:0]  dir_mask,
  output logic [PINS-1:0]  port_value
);

  logic [SIZE-1:0] frames [2][LINES];
  logic            front_is_b;
  logic            back_sel;
  logic [3:0]      row;
  logic [3:0]      cell_word [HALF_WIDTH];
  logic [SIZE-1:0] scan_word;
  logic [PINS-1:0] line_pin, scan_dir, scan_port;

  assign pop      = q_valid && (!out_valid || out_ready);
  assign back_sel = ~front_is_b;
  assign row      = q_cmd.pos[4:1];

  // Off-diagonal cells live in the word of their column; diagonal cells in the
  // extra word at the end.
  always_comb begin
    for (int i = 0; i < HALF_WIDTH; i++) begin
      logic [3:0] col;
      col = (q_cmd.pos[0] ? 4'(HALF_WIDTH) : 4'd0) + 4'(i);
      cell_word[i] = (col == row) ? 4'(SIZE) : col;
    end
  end

  always_comb begin
    scan_word = frames[front_is_b][q_cmd.line];
    line_pin  = PINS'(1) << PIN_OF_LINE[q_cmd.line];
    scan_dir  = remap_pins(scan_word) | line_pin;
    scan_port = (q_cmd.line == 4'(SIZE)) ? line_pin : (scan_dir & ~line_pin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_is_b <= 1'b0;
      for (int f = 0; f < 2; f++) begin
        for (int w = 0; w < LINES; w++) begin
          frames[f][w] <= '0;
        end
      end
    end else if (pop) begin
      case (q_cmd.op)
        OP_SWAP: front_is_b <= ~front_is_b;
        OP_WRITE: begin
          for (int i = 0; i < HALF_WIDTH; i++) begin
            frames[back_sel][cell_word[i]][row] <= q_cmd.data[i];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (q_cmd.op == OP_SCAN) begin
        kind       <= KIND_SCAN;
        echo_byte  <= '0;
        dir_mask   <= scan_dir;
        port_value <= scan_port;
      end else begin
        kind       <= KIND_ECHO;
        echo_byte  <= q_cmd.data;
        dir_mask   <= '0;
        port_value <= '0;
      end
    end
  end

endmodule

// ----- rtl/core/charlieplex_matrix_controller_top.sv -----
// Top level of the double-buffered charlieplexed LED matrix controller.
// Instantiates chmc_front, chmc_queue and chmc_back; depends on chmc_pkg.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | op, rx_byte
//  output  | out_valid / out_ready| kind, echo_byte, dir_mask, port_value
//
// Every transaction yields one result; one per cycle is sustained while out_ready is high.
// An accepted transaction is written into a queue entry, then moved from the
// queue into the output register of the back part once that register is free.
// Reset clears both frames, the buffer select, the write position and the scan line.
// A stalled output fills the two-entry queue, after which in_ready drops.
module charlieplex_matrix_controller_top import chmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  echo_byte,
  output logic [15:0] dir_mask,
  output logic [15:0] port_value
);

  logic push, pop, q_space, q_valid;
  cmd_t push_cmd, head_cmd;

  chmc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .rx_byte  (rx_byte),
    .q_space  (q_space),
    .push     (push),
    .cmd      (push_cmd)
  );

  chmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .not_empty (q_valid),
    .not_full  (q_space),
    .head      (head_cmd)
  );

  chmc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .echo_byte  (echo_byte),
    .dir_mask   (dir_mask),
    .port_value (port_value)
  );

endmodule

// ----- rtl/core/chmc_checker.sv -----
// Port-level checks for the charlieplexed matrix controller top level.
// Attached by the bind statement at the end of this file; no package needed.
module chmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [7:0]  echo_byte,
  input logic [15:0] dir_mask,
  input logic [15:0] port_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(echo_byte)
      && $stable(dir_mask) && $stable(port_value))
    else $error("output transaction changed while stalled");

  a_echo_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> dir_mask == 16'h0 && port_value == 16'h0)
    else $error("echo carries drive values");

  a_scan_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> echo_byte == 8'h0 && dir_mask != 16'h0)
    else $error("scan result has echo byte or no driven pin");

  a_port_driven: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> (port_value & ~dir_mask) == 16'h0)
    else $error("port level set on an undriven pin");

endmodule

bind charlieplex_matrix_controller_top chmc_checker u_chmc_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .kind       (kind),
  .echo_byte  (echo_byte),
  .dir_mask   (dir_mask),
  .port_value (port_value)
);

// ----- bench/chmc_drive_checker.sv -----
// Checker for the charlieplexed matrix controller: watches both channels, keeps its own
// copy of the frames and counters, and compares every result. Depends on chmc_pkg.
`timescale 1ns / 1ps

module chmc_drive_checker import chmc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        kind,
  input  logic [7:0]  echo_byte,
  input  logic [15:0] dir_mask,
  input  logic [15:0] port_value,
  output int          mismatch_count,
  output int          waiting_count,
  output int          result_count
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  echo;
    logic [15:0] dir;
    logic [15:0] port;
  } drive_result_t;

  drive_result_t expected_drive_q[$];

  logic [SIZE-1:0] frame_a [LINES];
  logic [SIZE-1:0] frame_b [LINES];
  logic            show_b;
  logic [4:0]      half_row;
  logic [3:0]      line_ptr;

  int errors;
  int results;

  function automatic logic [15:0] spread_word(input logic [SIZE-1:0] w);
    logic [15:0] pins;
    pins = '0;
    for (int i = 0; i < SIZE; i++) begin
      pins[PIN_OF_LINE[i]] = w[i];
    end
    return pins;
  endfunction

  // Applies one accepted transaction to the shadow state and returns its drive result.
  task automatic apply_transaction(input logic in_op, input logic [7:0] b,
                                   output drive_result_t res);
    logic [4:0]      pos;
    logic [3:0]      ln;
    logic [15:0]     p;
    logic [15:0]     dir;
    logic [SIZE-1:0] w;
    int              row;
    int              col;
    int              word_ix;
    res = '0;
    if (in_op == IN_BYTE) begin
      res.kind = KIND_ECHO;
      res.echo = b;
      if (b == CMD_REWIND) begin
        half_row = '0;
      end else if (b == CMD_SWAP) begin
        show_b = ~show_b;
      end else begin
        pos = (half_row < HALF_ROWS) ? half_row : '0;
        row = pos >> 1;
        for (int i = 0; i < HALF_WIDTH; i++) begin
          col = (pos[0] ? HALF_WIDTH : 0) + i;
          // Diagonal cells live in the extra word at index SIZE.
          word_ix = (row == col) ? SIZE : col;
          if (show_b) begin
            frame_a[word_ix][row] = b[i];
          end else begin
            frame_b[word_ix][row] = b[i];
          end
        end
        half_row = (pos == HALF_ROWS - 1) ? '0 : pos + 5'd1;
      end
    end else begin
      ln = (line_ptr <= SIZE) ? line_ptr : '0;
      p = 16'd1 << PIN_OF_LINE[ln];
      w = show_b ? frame_b[ln] : frame_a[ln];
      dir = spread_word(w) | p;
      res.kind = KIND_SCAN;
      res.dir = dir;
      res.port = (ln != SIZE) ? (dir & ~p) : p;
      line_ptr = (ln == SIZE) ? '0 : ln + 4'd1;
    end
  endtask

  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        frame_a[i] = '0;
        frame_b[i] = '0;
      end
      show_b = 1'b0;
      half_row = '0;
      line_ptr = '0;
      expected_drive_q.delete();
      errors = 0;
      results = 0;
    end else begin
      // The result of an earlier transaction is retired before a new one is queued.
      if (out_valid && out_ready) begin
        results++;
        if (expected_drive_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result kind=%0b echo=%02h dir=%04h port=%04h",
                     $realtime, kind, echo_byte, dir_mask, port_value);
          end
        end else begin
          want = expected_drive_q.pop_front();
          if (kind !== want.kind || echo_byte !== want.echo ||
              dir_mask !== want.dir || port_value !== want.port) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch expected kind=%0b echo=%02h dir=%04h port=%04h",
                       $realtime, want.kind, want.echo, want.dir, want.port);
              $display("%0t:          actual   kind=%0b echo=%02h dir=%04h port=%04h",
                       $realtime, kind, echo_byte, dir_mask, port_value);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_transaction(op, rx_byte, want);
        expected_drive_q.push_back(want);
      end
    end
    mismatch_count <= errors;
    waiting_count <= expected_drive_q.size();
    result_count <= results;
  end

endmodule

// ----- bench/charlieplex_matrix_controller_top_test.sv -----
// Top of the charlieplexed matrix controller testbench: clock, reset, stimulus and verdict.
// Depends on chmc_pkg, charlieplex_matrix_controller_top and chmc_drive_checker.
`timescale 1ns / 1ps

module charlieplex_matrix_controller_top_test;
  import chmc_pkg::*;

  localparam int ITEM_TARGET    = 1500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  localparam logic [7:0] EDGE_BYTES [6] = '{8'h1F, 8'hFF, 8'hC0, 8'hE0, 8'h15, 8'h0A};
  localparam logic [7:0] TICK_BYTES [3] = '{8'hFF, CMD_REWIND, CMD_SWAP};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = IN_BYTE;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  echo_byte;
  logic [15:0] dir_mask;
  logic [15:0] port_value;

  int mismatch_count;
  int waiting_count;
  int result_count;

  int burst_left = 0;
  int sent = 0;
  int writes_sent = 0;
  int rewinds_sent = 0;
  int swaps_sent = 0;
  int ticks_sent = 0;
  int quiet_cycles = 0;
  int sink_cycle = 0;
  int sink_mode = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  charlieplex_matrix_controller_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .echo_byte  (echo_byte),
    .dir_mask   (dir_mask),
    .port_value (port_value)
  );

  chmc_drive_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .echo_byte      (echo_byte),
    .dir_mask       (dir_mask),
    .port_value     (port_value),
    .mismatch_count (mismatch_count),
    .waiting_count  (waiting_count),
    .result_count   (result_count)
  );

  // The sink switches at random between always ready, random stalls, a fixed duty pattern
  // and mostly stalled.
  always @(posedge clk) begin
    sink_cycle++;
    if (sink_cycle % 300 == 0) begin
      sink_mode = $urandom_range(0, 3);
    end
    case (sink_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ((sink_cycle % 16) < 10);
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("charlieplex_matrix_controller_top regression: fail");
    $finish;
  end

  // Presents one transaction and holds it until accepted; bursts are usually separated by gaps.
  task automatic push_item(input logic item_op, input logic [7:0] item_byte);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    op <= item_op;
    rx_byte <= item_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    sent++;
    if (item_op == IN_TICK) begin
      ticks_sent++;
    end else if (item_byte == CMD_REWIND) begin
      rewinds_sent++;
    end else if (item_byte == CMD_SWAP) begin
      swaps_sent++;
    end else begin
      writes_sent++;
    end
  endtask

  initial begin
    int pick;
    int count;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty frame scan, with command values on the ignored byte field.
    foreach (TICK_BYTES[i]) push_item(IN_TICK, TICK_BYTES[i]);
    // Extreme data bytes, including ones whose upper bits look like commands.
    foreach (EDGE_BYTES[i]) push_item(IN_BYTE, EDGE_BYTES[i]);
    // Rewind and rewrite the first half row, which holds a diagonal cell.
    push_item(IN_BYTE, CMD_REWIND);
    push_item(IN_BYTE, 8'h1F);
    // Show the written frame and scan past the diagonal line and the wrap.
    push_item(IN_BYTE, CMD_SWAP);
    repeat (LINES) push_item(IN_TICK, 8'h00);
    push_item(IN_BYTE, CMD_SWAP);

    while (sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick <= 4) begin
        // Frame upload: usually a full rewind, twenty half rows, swap, then scans.
        if ($urandom_range(0, 4) != 0) push_item(IN_BYTE, CMD_REWIND);
        count = ($urandom_range(0, 3) != 0) ? HALF_ROWS : $urandom_range(1, 30);
        repeat (count) push_item(IN_BYTE, 8'($urandom));
        if ($urandom_range(0, 4) != 0) push_item(IN_BYTE, CMD_SWAP);
        repeat ($urandom_range(LINES, 3 * LINES)) push_item(IN_TICK, 8'($urandom));
      end else if (pick <= 7) begin
        repeat ($urandom_range(1, 15)) push_item(IN_TICK, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 3))
            0: push_item(1'($urandom), CMD_REWIND);
            1: push_item(1'($urandom), CMD_SWAP);
            default: push_item(1'($urandom), 8'($urandom));
          endcase
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions: %0d half-row writes, %0d rewinds, %0d swaps, %0d ticks.",
             sent, writes_sent, rewinds_sent, swaps_sent, ticks_sent);
    $display("Checked %0d results, %0d mismatches.", result_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("charlieplex_matrix_controller_top regression: pass");
    end else begin
      $display("charlieplex_matrix_controller_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/chmc_pkg.sv
rtl/core/chmc_front.sv
rtl/core/chmc_queue.sv
rtl/core/chmc_back.sv
rtl/core/charlieplex_matrix_controller_top.sv
rtl/core/chmc_checker.sv
bench/chmc_drive_checker.sv
bench/charlieplex_matrix_controller_top_test.sv
